// ----- rtl/psc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the point versus sphere contact block.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Magnitude width of one axis difference that can still be a hit
    localparam int MAG_W       = 31;
    // Squared distance width on a hit (below radius squared)
    localparam int SQ_W        = 62;
    // Root stages: one result bit per stage
    localparam int SQRT_STAGES = 32;
    // Divider stages: one quotient bit per stage
    localparam int DIV_STAGES  = 31;
    // Queue between front and back
    localparam int FIFO_AW     = 2;
    localparam int FIFO_DEPTH  = 1 << FIFO_AW;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } t_reg;

    // Classified word handed from front to back
    typedef struct packed {
        logic                        miss;
        logic [2:0]                  sgn;
        logic [2:0][MAG_W-1:0]       a;
    } t_item;

    // Side band carried through the dividers
    typedef struct packed {
        logic                        miss;
        logic                        dzero;
        logic [2:0]                  sgn;
        logic [MAG_W-1:0]            dlen;
    } t_dsb;

    // One step of the bitwise integer square root
    typedef struct packed {
        logic [SQ_W-1:0]             x;
        logic [63:0]                 res;
    } t_sq;

    function automatic t_sq sqrt_step(input t_sq s, input logic [63:0] b);
        t_sq        o;
        logic [63:0] t;
        t = s.res + b;
        if ({2'b00, s.x} >= t) begin
            o.x   = s.x - t[SQ_W-1:0];
            o.res = (s.res >> 1) + b;
        end else begin
            o.x   = s.x;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // One restoring division step: w holds {remainder, numerator/quotient}
    function automatic logic [2*MAG_W-1:0] div_step(input logic [2*MAG_W-1:0] w,
                                                    input logic [MAG_W-1:0] dv);
        logic [MAG_W:0]   t;
        logic [MAG_W:0]   d;
        logic [MAG_W-1:0] rem;
        logic             q;
        t = {w[2*MAG_W-1:MAG_W], w[MAG_W-1]};
        if (t >= {1'b0, dv}) begin
            d   = t - {1'b0, dv};
            rem = d[MAG_W-1:0];
            q   = 1'b1;
        end else begin
            rem = t[MAG_W-1:0];
            q   = 1'b0;
        end
        return {rem, w[MAG_W-2:0], q};
    endfunction

endpackage

// ----- rtl/psc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_front
// Takes a particle position, forms the offset from the centre and sorts out
// points that lie at or beyond the radius on any single axis.
// ----------------------------------------------------------------------------
module psc_front (
    input  logic                  i_valid,
    input  logic [31:0]           i_point_x,
    input  logic [31:0]           i_point_y,
    input  logic [31:0]           i_point_z,
    input  logic [31:0]           i_center_x,
    input  logic [31:0]           i_center_y,
    input  logic [31:0]           i_center_z,
    input  logic [30:0]           i_radius,
    input  logic                  i_full,
    output logic                  o_ready,
    output logic                  o_push,
    output psc_pkg::t_item        o_item
);

    logic [2:0][32:0] w_d;
    logic [2:0][32:0] w_mag;
    logic [2:0]       w_far;

    // Offsets and per-axis early rejection
    always_comb begin
        w_d[0] = {i_point_x[31], i_point_x} - {i_center_x[31], i_center_x};
        w_d[1] = {i_point_y[31], i_point_y} - {i_center_y[31], i_center_y};
        w_d[2] = {i_point_z[31], i_point_z} - {i_center_z[31], i_center_z};
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_d[i][32] ? (33'd0 - w_d[i]) : w_d[i];
            w_far[i] = w_mag[i] >= {2'b00, i_radius};
        end
        o_item.miss = |w_far;
        for (int i = 0; i < 3; i++) begin
            o_item.sgn[i] = w_d[i][32];
            o_item.a[i]   = o_item.miss ? '0 : w_mag[i][psc_pkg::MAG_W-1:0];
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ----- rtl/psc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module psc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  psc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output psc_pkg::t_item o_item
);

    psc_pkg::t_item                 r_mem [psc_pkg::FIFO_DEPTH];
    logic [psc_pkg::FIFO_AW-1:0]    r_wr;
    logic [psc_pkg::FIFO_AW-1:0]    r_rd;
    logic [psc_pkg::FIFO_AW:0]      r_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (psc_pkg::FIFO_AW+1)'(psc_pkg::FIFO_DEPTH);
    assign o_item  = r_mem[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

// ----- rtl/psc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_back
// Pipelined contact evaluation: squares, sum and radius test, bitwise square
// root, then restoring dividers for normal and surface offset, and the
// output register.
// ----------------------------------------------------------------------------
module psc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  psc_pkg::t_item        i_item,
    output logic                  o_pop,
    input  logic [31:0]           i_center_x,
    input  logic [31:0]           i_center_y,
    input  logic [31:0]           i_center_z,
    input  logic [30:0]           i_radius,
    input  logic [61:0]           i_radius_sq,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_hit,
    output logic [2:0][31:0]      o_surface,
    output logic [2:0][17:0]      o_normal,
    output logic [30:0]           o_depth
);

    localparam int NS = psc_pkg::SQRT_STAGES;
    localparam int ND = psc_pkg::DIV_STAGES;
    localparam int W2 = 2 * psc_pkg::MAG_W;

    logic                    w_adv;

    // Square stage
    logic                    r_av;
    psc_pkg::t_item          r_ait;
    logic [2:0][61:0]        r_asq;

    // Root stages, index 0 holds the summed square
    logic                    r_sv  [NS+1];
    psc_pkg::t_item          r_sit [NS+1];
    psc_pkg::t_sq            r_sq  [NS+1];
    psc_pkg::t_sq            n_sq  [NS+1];
    logic [63:0]             w_sum;
    logic                    w_bmiss;
    psc_pkg::t_item          w_sit;

    // Divider stages, index 0 holds the numerators
    logic                    r_dv  [ND+1];
    psc_pkg::t_dsb           r_dsb [ND+1];
    logic [2:0][W2-1:0]      r_wo  [ND+1];
    logic [2:0][W2-1:0]      r_wn  [ND+1];
    logic [2:0][W2-1:0]      n_wo  [ND+1];
    logic [2:0][W2-1:0]      n_wn  [ND+1];

    // Output evaluation
    logic [2:0][31:0]        w_c;
    logic [2:0][30:0]        w_qo;
    logic [2:0][30:0]        w_qn;
    logic [2:0][33:0]        w_off;
    logic [2:0][33:0]        w_s;
    logic [2:0][31:0]        w_n;
    logic [2:0][31:0]        n_surface;
    logic [2:0][17:0]        n_normal;
    logic [30:0]             n_depth;
    logic                    n_hit;

    // Whole pipeline moves when the output register is free or drained
    assign w_adv = !o_valid || i_ready;
    assign o_pop = w_adv && i_valid;

    // Sum of squares and the exact radius test
    assign w_sum   = 64'(r_asq[0]) + 64'(r_asq[1]) + 64'(r_asq[2]);
    assign w_bmiss = r_ait.miss || (w_sum >= {2'b00, i_radius_sq});

    // Merge the radius test into the classified word
    always_comb begin
        w_sit      = r_ait;
        w_sit.miss = w_bmiss;
    end

    // Root steps
    always_comb begin
        n_sq[0].x   = w_bmiss ? '0 : w_sum[61:0];
        n_sq[0].res = '0;
        for (int k = 0; k < NS; k++) begin
            n_sq[k+1] = psc_pkg::sqrt_step(r_sq[k], 64'd1 << (62 - 2 * k));
        end
    end

    // Numerators and division steps
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_wo[0][i] = 62'(i_radius) * 62'(r_sit[NS].a[i]);
            n_wn[0][i] = 62'(r_sit[NS].a[i]) << FRAC_BITS;
        end
        for (int j = 0; j < ND; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_wo[j+1][i] = psc_pkg::div_step(r_wo[j][i], r_dsb[j].dlen);
                n_wn[j+1][i] = psc_pkg::div_step(r_wn[j][i], r_dsb[j].dlen);
            end
        end
    end

    // Final assembly: sign, saturate, mask
    always_comb begin
        w_c[0] = i_center_x;
        w_c[1] = i_center_y;
        w_c[2] = i_center_z;
        n_hit  = r_dv[ND] && !r_dsb[ND].miss;
        for (int i = 0; i < 3; i++) begin
            w_qo[i]  = r_dsb[ND].dzero ? '0 : r_wo[ND][i][30:0];
            w_qn[i]  = r_dsb[ND].dzero ? '0 : r_wn[ND][i][30:0];
            w_off[i] = r_dsb[ND].sgn[i] ? (34'd0 - 34'(w_qo[i])) : 34'(w_qo[i]);
            w_s[i]   = {{2{w_c[i][31]}}, w_c[i]} + w_off[i];
            w_n[i]   = r_dsb[ND].sgn[i] ? (32'd0 - 32'(w_qn[i])) : 32'(w_qn[i]);
            if (!w_s[i][33] && (w_s[i][32:31] != 2'b00)) begin
                n_surface[i] = 32'h7fff_ffff;
            end else if (w_s[i][33] && (w_s[i][32:31] != 2'b11)) begin
                n_surface[i] = 32'h8000_0000;
            end else begin
                n_surface[i] = w_s[i][31:0];
            end
            n_normal[i] = w_n[i][17:0];
            if (!n_hit) begin
                n_surface[i] = '0;
                n_normal[i]  = '0;
            end
        end
        n_depth = n_hit ? (i_radius - r_dsb[ND].dlen) : '0;
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av    <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k <= NS; k++) r_sv[k] <= 1'b0;
            for (int j = 0; j <= ND; j++) r_dv[j] <= 1'b0;
        end else if (w_adv) begin
            r_av    <= i_valid;
            r_sv[0] <= r_av;
            for (int k = 0; k < NS; k++) r_sv[k+1] <= r_sv[k];
            r_dv[0] <= r_sv[NS];
            for (int j = 0; j < ND; j++) r_dv[j+1] <= r_dv[j];
            o_valid <= r_dv[ND];
        end
    end

    // Data path
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ait <= i_item;
            for (int i = 0; i < 3; i++) begin
                r_asq[i] <= 62'(i_item.a[i]) * 62'(i_item.a[i]);
            end
            r_sit[0] <= w_sit;
            for (int k = 0; k <= NS; k++) r_sq[k] <= n_sq[k];
            for (int k = 0; k < NS; k++) r_sit[k+1] <= r_sit[k];
            r_dsb[0].miss  <= r_sit[NS].miss;
            r_dsb[0].sgn   <= r_sit[NS].sgn;
            r_dsb[0].dlen  <= r_sq[NS].res[30:0];
            r_dsb[0].dzero <= r_sq[NS].res[30:0] == '0;
            for (int j = 0; j <= ND; j++) begin
                r_wo[j] <= n_wo[j];
                r_wn[j] <= n_wn[j];
            end
            for (int j = 0; j < ND; j++) r_dsb[j+1] <= r_dsb[j];
            o_hit     <= n_hit;
            o_surface <= n_surface;
            o_normal  <= n_normal;
            o_depth   <= n_depth;
        end
    end

endmodule

// ----- rtl/point_sphere_contact.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_sphere_contact
// Point versus sphere contact test with surface projection and normal.
// ----------------------------------------------------------------------------
// Takes one particle position per clock and returns one result word per
// position, in order, at one word per cycle while the output side keeps up
// and the queue has room. Each position passes through the queue write, the
// square register, the sum and radius test, 32 square root stages (one
// result bit each), the numerator multiply, 31 stages of restoring division
// (one quotient bit each) and the output register. The user must write the
// sphere centre and radius over the register port only while no word is in
// flight; the block itself does not enforce it.
module point_sphere_contact #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,  // point_x, point_y, point_z
    // Output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [183:0]  m_axis_tdata,  // surface_x/y/z, normal_x/y/z, depth, pad
    output logic          m_axis_tuser,  // hit
    // Register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [31:0]        r_center_x;
    logic [31:0]        r_center_y;
    logic [31:0]        r_center_z;
    logic [30:0]        r_radius;
    logic [61:0]        r_radius_sq;

    logic               w_push;
    logic               w_full;
    logic               w_qvalid;
    logic               w_pop;
    psc_pkg::t_item     w_fitem;
    psc_pkg::t_item     w_qitem;
    logic [2:0][31:0]   w_surface;
    logic [2:0][17:0]   w_normal;
    logic [30:0]        w_depth;
    psc_pkg::t_reg      w_reg;

    assign pready = 1'b1;
    assign w_reg  = psc_pkg::t_reg'(paddr[3:2]);

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= 31'd1 << FRAC_BITS;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                psc_pkg::REG_CENTER_X: r_center_x <= pwdata;
                psc_pkg::REG_CENTER_Y: r_center_y <= pwdata;
                psc_pkg::REG_CENTER_Z: r_center_z <= pwdata;
                psc_pkg::REG_RADIUS:   r_radius   <= pwdata[30:0];
            endcase
        end
    end

    // Hold radius squared for the hit test
    always_ff @(posedge i_clk) begin
        r_radius_sq <= 62'(r_radius) * 62'(r_radius);
    end

    // Read back
    always_comb begin
        unique case (w_reg)
            psc_pkg::REG_CENTER_X: prdata = r_center_x;
            psc_pkg::REG_CENTER_Y: prdata = r_center_y;
            psc_pkg::REG_CENTER_Z: prdata = r_center_z;
            psc_pkg::REG_RADIUS:   prdata = {1'b0, r_radius};
        endcase
    end

    psc_front u_front (
        .i_valid    (s_axis_tvalid),
        .i_point_x  (s_axis_tdata[31:0]),
        .i_point_y  (s_axis_tdata[63:32]),
        .i_point_z  (s_axis_tdata[95:64]),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_radius   (r_radius),
        .i_full     (w_full),
        .o_ready    (s_axis_tready),
        .o_push     (w_push),
        .o_item     (w_fitem)
    );

    psc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_full  (w_full),
        .o_item  (w_qitem)
    );

    psc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_qvalid),
        .i_item      (w_qitem),
        .o_pop       (w_pop),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .i_center_z  (r_center_z),
        .i_radius    (r_radius),
        .i_radius_sq (r_radius_sq),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_hit       (m_axis_tuser),
        .o_surface   (w_surface),
        .o_normal    (w_normal),
        .o_depth     (w_depth)
    );

    // Pack result word
    assign m_axis_tdata = {3'b000, w_depth, w_normal[2], w_normal[1], w_normal[0],
                           w_surface[2], w_surface[1], w_surface[0]};

    // A miss carries an all-zero payload
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss word with non-zero payload");

    // A hit always has some penetration
    a_hit_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[180:150] != '0)
        else $error("hit word with zero depth");

    // Depth never exceeds the radius
    a_depth_rad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[180:150] <= r_radius)
        else $error("depth beyond radius");

endmodule
